### src/hsfc_pkg.sv
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared types and constants of the humidity sensor frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hsfc_pkg;

    // Modbus CRC-16, reflected form
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // sign-magnitude temperature
    localparam logic [15:0] SIGN_BIT = 16'h8000;
    localparam logic [15:0] MAG_MASK = 16'h7FFF;

    // configuration registers
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FUNC_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_REG_COUNT = 1'b1;
    localparam logic [7:0] FUNC_CODE_RESET = 8'h03;
    localparam logic [7:0] REG_COUNT_RESET = 8'h04;

    // byte positions inside a frame
    typedef logic [2:0] t_pos;
    localparam t_pos POS_FUNC     = 3'd0;
    localparam t_pos POS_COUNT    = 3'd1;
    localparam t_pos POS_HUM_HI   = 3'd2;
    localparam t_pos POS_HUM_LO   = 3'd3;
    localparam t_pos POS_TEMP_HI  = 3'd4;
    localparam t_pos POS_TEMP_LO  = 3'd5;
    localparam t_pos POS_CRC_LO   = 3'd6;
    localparam t_pos POS_CRC_HI   = 3'd7;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_HEADER = 2'd1,
        STATUS_BAD_CRC    = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        t_status            frame_status;
        logic [15:0]        humidity_tenths;
        logic signed [15:0] temperature_tenths;
    } t_out_word;

    // frame tracker -> top
    typedef struct packed {
        logic      last;  // byte in hand closes the frame
        t_out_word word;
    } t_frame_result;

endpackage

`default_nettype wire

### src/hsfc_stream_if.sv
// ----------------------------------------------------------------------------
// hsfc_stream_if
// Valid/ready channel carrying one word of payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsfc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/hsfc_crc_byte.sv
// ----------------------------------------------------------------------------
// hsfc_crc_byte
// One byte of reflected CRC-16, eight bit steps unrolled.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfc_crc_byte (
    input  wire logic [15:0] i_crc,
    input  wire logic [7:0]  i_data,
    output logic      [15:0] o_crc
);

    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {8'h00, i_data};
        for (int k = 0; k < 8; k++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ hsfc_pkg::CRC_POLY;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

`default_nettype wire

### src/hsfc_frame.sv
// ----------------------------------------------------------------------------
// hsfc_frame
// Frame state: byte position, running CRC, header flag, readings.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfc_frame (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire hsfc_pkg::t_in_word   i_word,
    input  wire logic [7:0]           i_exp_func,
    input  wire logic [7:0]           i_exp_count,
    output hsfc_pkg::t_frame_result   o_result
);

    hsfc_pkg::t_pos r_pos, n_pos;
    logic [15:0]    r_crc, n_crc;
    logic           r_hdr_ok, n_hdr_ok;
    logic [15:0]    r_raw_hum, n_raw_hum;
    logic [15:0]    r_raw_temp, n_raw_temp;
    logic [7:0]     r_crc_lo, n_crc_lo;
    logic [15:0]    r_held_hum, n_held_hum;
    logic [15:0]    r_held_temp, n_held_temp;

    hsfc_pkg::t_pos   w_pos;
    logic [15:0]      w_crc_base;
    logic             w_hdr_base;
    logic [15:0]      w_crc_upd;
    logic [15:0]      w_rx_crc;
    logic [15:0]      w_mag;
    hsfc_pkg::t_status w_status;

    // start flag restarts the frame on this byte
    assign w_pos      = i_word.frame_start ? hsfc_pkg::POS_FUNC : r_pos;
    assign w_crc_base = i_word.frame_start ? hsfc_pkg::CRC_INIT : r_crc;
    assign w_hdr_base = i_word.frame_start ? 1'b1 : r_hdr_ok;

    hsfc_crc_byte u_crc (
        .i_crc  (w_crc_base),
        .i_data (i_word.rx_byte),
        .o_crc  (w_crc_upd)
    );

    assign w_rx_crc = {i_word.rx_byte, r_crc_lo};
    assign w_mag    = r_raw_temp & hsfc_pkg::MAG_MASK;

    always_comb begin
        n_pos       = w_pos + 3'd1;
        n_crc       = (w_pos < hsfc_pkg::POS_CRC_LO) ? w_crc_upd : w_crc_base;
        n_hdr_ok    = w_hdr_base;
        n_raw_hum   = r_raw_hum;
        n_raw_temp  = r_raw_temp;
        n_crc_lo    = r_crc_lo;
        n_held_hum  = r_held_hum;
        n_held_temp = r_held_temp;
        w_status    = hsfc_pkg::STATUS_OK;

        case (w_pos)
            hsfc_pkg::POS_FUNC: begin
                if (i_word.rx_byte != i_exp_func) n_hdr_ok = 1'b0;
            end
            hsfc_pkg::POS_COUNT: begin
                if (i_word.rx_byte != i_exp_count) n_hdr_ok = 1'b0;
            end
            hsfc_pkg::POS_HUM_HI:  n_raw_hum[15:8]  = i_word.rx_byte;
            hsfc_pkg::POS_HUM_LO:  n_raw_hum[7:0]   = i_word.rx_byte;
            hsfc_pkg::POS_TEMP_HI: n_raw_temp[15:8] = i_word.rx_byte;
            hsfc_pkg::POS_TEMP_LO: n_raw_temp[7:0]  = i_word.rx_byte;
            hsfc_pkg::POS_CRC_LO:  n_crc_lo         = i_word.rx_byte;
            default: ;
        endcase

        if (w_pos == hsfc_pkg::POS_CRC_HI) begin
            if (!w_hdr_base) begin
                w_status = hsfc_pkg::STATUS_BAD_HEADER;
            end else if (w_rx_crc != w_crc_base) begin
                w_status = hsfc_pkg::STATUS_BAD_CRC;
            end else begin
                n_held_hum = r_raw_hum;
                if ((r_raw_temp & hsfc_pkg::SIGN_BIT) != 16'h0000) begin
                    n_held_temp = 16'h0000 - w_mag;
                end else begin
                    n_held_temp = r_raw_temp;
                end
            end
            // frame done: restart
            n_pos    = hsfc_pkg::POS_FUNC;
            n_crc    = hsfc_pkg::CRC_INIT;
            n_hdr_ok = 1'b1;
        end
    end

    assign o_result.last                    = (w_pos == hsfc_pkg::POS_CRC_HI);
    assign o_result.word.frame_status       = w_status;
    assign o_result.word.humidity_tenths    = n_held_hum;
    assign o_result.word.temperature_tenths = $signed(n_held_temp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= hsfc_pkg::POS_FUNC;
            r_crc       <= hsfc_pkg::CRC_INIT;
            r_hdr_ok    <= 1'b1;
            r_held_hum  <= 16'h0000;
            r_held_temp <= 16'h0000;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_hdr_ok    <= n_hdr_ok;
            r_held_hum  <= n_held_hum;
            r_held_temp <= n_held_temp;
        end
    end

    // every frame writes these before they are read
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_raw_hum  <= n_raw_hum;
            r_raw_temp <= n_raw_temp;
            r_crc_lo   <= n_crc_lo;
        end
    end

endmodule

`default_nettype wire

### src/humidity_sensor_frame_checker.sv
// ----------------------------------------------------------------------------
// humidity_sensor_frame_checker
// Checks 8-byte sensor response frames: header, Modbus CRC-16, readings.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake       word
//  -------  ---  --------------  ------------------------------------------
//  i_rx     in   valid/ready     rx_byte[7:0], frame_start
//  o_res    out  valid/ready     frame_status[1:0], humidity_tenths[15:0],
//                                temperature_tenths[15:0] (signed)
//  cfg      in   i_cfg_we only   i_cfg_idx, i_cfg_data[7:0]
//
//  One byte per cycle sustained. A byte is held in the input register,
//  then updates the frame state; the eighth byte of a frame also
//  loads the result register, which drives o_res.
//  Reset (synchronous, active low) restarts the frame, clears held readings
//  and loads the default header values.
//  A stalled result holds only a closing byte; later bytes wait behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_sensor_frame_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    hsfc_stream_if.sink                            i_rx,
    hsfc_stream_if.source                          o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [hsfc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [hsfc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // header registers
    logic [7:0] r_exp_func;
    logic [7:0] r_exp_count;

    // input register
    logic               r_s1_valid;
    hsfc_pkg::t_in_word r_s1_word;

    // result register
    logic                r_out_valid;
    hsfc_pkg::t_out_word r_out_word;

    hsfc_pkg::t_frame_result w_result;
    logic w_out_free;
    logic w_advance;
    logic w_in_take;

    assign w_out_free = !r_out_valid || o_res.ready;
    // non-closing bytes never need the result register
    assign w_advance  = r_s1_valid && (!w_result.last || w_out_free);
    assign i_rx.ready = !r_s1_valid || w_advance;
    assign w_in_take  = i_rx.valid && i_rx.ready;

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out_word;

    hsfc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_word      (r_s1_word),
        .i_exp_func  (r_exp_func),
        .i_exp_count (r_exp_count),
        .o_result    (w_result)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_func  <= hsfc_pkg::FUNC_CODE_RESET;
            r_exp_count <= hsfc_pkg::REG_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hsfc_pkg::CFG_IDX_FUNC_CODE: r_exp_func  <= i_cfg_data[7:0];
                hsfc_pkg::CFG_IDX_REG_COUNT: r_exp_count <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_advance && w_result.last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_word <= i_rx.payload;
        end
        if (w_advance && w_result.last) begin
            r_out_word <= w_result.word;
        end
    end

    // closing byte must wait while a result is stuck
    a_close_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_result.last && r_out_valid && !o_res.ready)
            |-> (!w_advance && !i_rx.ready))
        else $error("closing byte advanced over a stalled result");

    // a closing byte that advances always shows a result next cycle
    a_close_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_result.last) |=> r_out_valid)
        else $error("closing byte produced no result");

    // accepted byte lands in the input register
    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_s1_valid)
        else $error("accepted byte lost");

    // no invalid status code leaves the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_word.frame_status == hsfc_pkg::STATUS_OK
            || r_out_word.frame_status == hsfc_pkg::STATUS_BAD_HEADER
            || r_out_word.frame_status == hsfc_pkg::STATUS_BAD_CRC))
        else $error("invalid frame status");

endmodule

`default_nettype wire
